@@ rtl/expected_key_tracker_assert.svh @@
// assertion macros for the expected key tracker rtl
`ifndef EXPECTED_KEY_TRACKER_ASSERT_SVH
`define EXPECTED_KEY_TRACKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define EKT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define EKT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ekt_pkg.sv @@
// types and constants shared by the expected key tracker
`default_nettype none

package ekt_pkg;

  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_CLEAR    = 2'd1;
  localparam logic [1:0] OP_CLEAR_CH = 2'd2;
  localparam logic [1:0] OP_PRESS    = 2'd3;

  localparam logic [1:0] RES_NONE     = 2'd0;
  localparam logic [1:0] RES_EXPECTED = 2'd1;
  localparam logic [1:0] RES_SKIPPED  = 2'd2;

  localparam logic [0:0] REG_KEEP_LIT       = 1'b0;
  localparam logic [0:0] REG_HOLD_WINDOW_US = 1'b1;

  localparam logic [31:0] HOLD_WINDOW_RESET = 32'd100000;
  localparam logic [8:0]  COUNT_MAX         = 9'd511;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  pitch;
    logic [6:0]  velocity;
    logic [3:0]  channel;
    logic        all_channels;
    logic [7:0]  future;
    logic        mark;
    logic [31:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic [1:0] press_result;
    logic [7:0] skipped_distance;
    logic [8:0] pending_count;
  } out_item_t;

  // one table entry; liveness is kept in flip-flops outside the memory
  typedef struct packed {
    logic        pressed;
    logic [6:0]  velocity;
    logic [3:0]  channel;
    logic [7:0]  future;
    logic        marked;
    logic [31:0] release_time;
  } entry_t;

  // update decided for one entry
  typedef struct packed {
    logic       mem_we;
    entry_t     wdata;
    logic       live_wr;
    logic       live_val;
    logic [8:0] count_nxt;
    logic [1:0] press_result;
    logic [7:0] skipped_distance;
  } rmw_t;

endpackage

`default_nettype wire

@@ rtl/ekt_chan_if.sv @@
// valid/ready channel carrying one payload beat
`default_nettype none

interface ekt_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/expected_key_tracker.sv @@
// Expected key tracker: per-pitch table of expected notes with a pending count.
// Items arrive on in_ch (valid/ready); each yields one result beat on out_ch.
// Add note, clear note and key press go through accept, memory read, and
// update with write-back. The entry memory has one registered read port, so an
// item is finished and written back before the next one reads.
// Clear all flash-clears the per-entry live flops.
// Clear by channel walks the memory one entry per cycle.
// Results go into an output register; the next item is taken while a result
// waits, and an item only stalls in its update cycle if out_ch still holds an
// untaken beat.
// Reset (rst_n low at a clock edge) makes every entry idle, zeroes the count,
// turns keep-lit mode off and sets the hold window to 100000 us; entry payload
// holds no reset value and needs no clearing pass.
// cfg_we writes cfg_wdata into register cfg_index (0 keep-lit mode, 1 hold
// window in us) at the clock edge; the user must do so only while the block is idle (not enforced).
`default_nettype none

`include "expected_key_tracker_assert.svh"

module expected_key_tracker import ekt_pkg::*; #(
  parameter int NUM_KEYS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ekt_chan_if.sink         in_ch,
  ekt_chan_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  localparam int KEY_W = $clog2(NUM_KEYS);
  localparam int CNT_W = KEY_W + 1;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_SWEEP, S_EXEC} state_t;

  state_t              state_r;
  in_item_t            item_r;
  out_item_t           out_data_r;
  out_item_t           out_nxt;
  logic                out_valid_r;
  logic [NUM_KEYS-1:0] live_r;
  logic [NUM_KEYS-1:0] live_nxt;
  logic [8:0]          count_r;
  logic [8:0]          count_nxt;
  logic                lit_r;
  logic [31:0]         hold_r;
  logic [CNT_W-1:0]    sweep_cnt_r;
  logic                chk_vld_r;
  logic [KEY_W-1:0]    chk_addr_r;

  logic                out_free;
  logic                accept;
  logic                issue;
  logic                finish;
  logic                is_clr_ch;
  logic                in_range;
  logic [KEY_W-1:0]    item_addr;
  logic                mem_we;
  logic                mem_re;
  logic [KEY_W-1:0]    mem_raddr;
  logic [$bits(entry_t)-1:0] mem_rdata;
  entry_t              rd;
  rmw_t                dec;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign accept    = in_ch.valid && (state_r == S_IDLE);
  assign issue     = (state_r == S_SWEEP) && (sweep_cnt_r < CNT_W'(NUM_KEYS));
  assign finish    = (state_r == S_EXEC) && out_free;
  assign is_clr_ch = item_r.operation == OP_CLEAR_CH;
  assign in_range  = {1'b0, item_r.pitch} < 9'(NUM_KEYS);
  assign item_addr = item_r.pitch[KEY_W-1:0];
  assign mem_re    = (state_r == S_READ) || issue;
  assign mem_raddr = (state_r == S_SWEEP) ? sweep_cnt_r[KEY_W-1:0] : item_addr;
  assign mem_we    = finish && !is_clr_ch && dec.mem_we;
  assign rd        = entry_t'(mem_rdata);

  assign in_ch.ready  = state_r == S_IDLE;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  ekt_mem #(
    .DEPTH (NUM_KEYS),
    .WIDTH ($bits(entry_t))
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (item_addr),
    .wdata (dec.wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ekt_rmw u_rmw (
    .item           (item_r),
    .rd             (rd),
    .live           (live_r[item_addr]),
    .in_range       (in_range),
    .count          (count_r),
    .keep_lit       (lit_r),
    .hold_window_us (hold_r),
    .dec            (dec)
  );

  always_comb begin
    live_nxt = live_r;
    // sweep: the entry read last cycle goes idle when its channel matches
    if (state_r == S_SWEEP && chk_vld_r && rd.channel == item_r.channel) begin
      live_nxt[chk_addr_r] = 1'b0;
    end
    if (finish) begin
      if (is_clr_ch) begin
        if (item_r.all_channels) begin
          live_nxt = '0;
        end
      end else if (dec.live_wr) begin
        live_nxt[item_addr] = dec.live_val;
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (finish) begin
      if (is_clr_ch) begin
        count_nxt = item_r.all_channels ? 9'd0 : count_r;
      end else begin
        count_nxt = dec.count_nxt;
      end
    end
  end

  assign out_nxt.press_result     = is_clr_ch ? RES_NONE : dec.press_result;
  assign out_nxt.skipped_distance = is_clr_ch ? 8'd0 : dec.skipped_distance;
  assign out_nxt.pending_count    = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      live_r      <= '0;
      count_r     <= 9'd0;
      lit_r       <= 1'b0;
      hold_r      <= HOLD_WINDOW_RESET;
      sweep_cnt_r <= '0;
      chk_vld_r   <= 1'b0;
    end else begin
      live_r  <= live_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_KEEP_LIT:       lit_r  <= cfg_wdata[0];
          REG_HOLD_WINDOW_US: hold_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            item_r      <= in_ch.data;
            sweep_cnt_r <= '0;
            chk_vld_r   <= 1'b0;
            if (in_ch.data.operation == OP_CLEAR_CH) begin
              state_r <= in_ch.data.all_channels ? S_EXEC : S_SWEEP;
            end else begin
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          state_r <= S_EXEC;
        end
        S_SWEEP: begin
          chk_vld_r  <= issue;
          chk_addr_r <= sweep_cnt_r[KEY_W-1:0];
          if (issue) begin
            sweep_cnt_r <= sweep_cnt_r + CNT_W'(1);
          end else if (!chk_vld_r) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            out_data_r <= out_nxt;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `EKT_ASSERT_IMP(a_we_in_update, mem_we, (state_r == S_EXEC) && out_free, "entry write outside update")
  `EKT_ASSERT_NXT(a_clear_all, finish && is_clr_ch && item_r.all_channels, (live_r == '0) && (count_r == 9'd0), "clear all left state behind")
  `EKT_ASSERT_NXT(a_item_held, state_r != S_IDLE, $stable(item_r), "item changed while busy")
  `EKT_ASSERT_NXT(a_result_loaded, finish, out_valid_r && (out_data_r.pending_count == count_r), "result beat not loaded")

endmodule

`default_nettype wire

@@ rtl/ekt_mem.sv @@
// single-port-write, registered-read entry memory
`default_nettype none

module ekt_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 53
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/ekt_rmw.sv @@
// per-entry update rules for add, clear and key press
`default_nettype none

module ekt_rmw import ekt_pkg::*; (
  input  wire in_item_t    item,
  input  wire entry_t      rd,
  input  wire logic        live,
  input  wire logic        in_range,
  input  wire logic [8:0]  count,
  input  wire logic        keep_lit,
  input  wire logic [31:0] hold_window_us,
  output      rmw_t        dec
);

  logic        is_exp;
  logic        is_prs;
  logic        clr_one;
  logic        clr_mark;
  logic        add_go;
  logic        had_mark;
  logic        up;
  logic        dn;
  logic [31:0] age;
  logic [8:0]  c_up;

  assign is_exp = live && !rd.pressed;
  assign is_prs = live && rd.pressed;
  assign age    = item.now_us - rd.release_time;

  always_comb begin
    dec.mem_we           = 1'b0;
    dec.wdata            = rd;
    dec.live_wr          = 1'b0;
    dec.live_val         = live;
    dec.press_result     = RES_NONE;
    dec.skipped_distance = 8'd0;
    clr_one  = 1'b0;
    clr_mark = 1'b0;
    add_go   = 1'b0;
    had_mark = 1'b0;
    up       = 1'b0;
    dn       = 1'b0;
    if (in_range) begin
      case (item.operation)
        OP_ADD: begin
          if (item.velocity == 7'd0) begin
            clr_one = 1'b1;
          end else begin
            add_go = 1'b1;
            if (is_exp) begin
              if (item.velocity == rd.velocity && item.channel == rd.channel &&
                  item.future == rd.future) begin
                add_go = 1'b0;
              end else if (item.future == 8'd0 && rd.future != 8'd0) begin
                up       = 1'b1;
                had_mark = rd.marked;
              end else if (item.future > rd.future ||
                           (item.future == rd.future && item.velocity < rd.velocity)) begin
                add_go = 1'b0;
              end
            end else if (item.future == 8'd0) begin
              up = 1'b1;
            end
            if (add_go) begin
              dec.mem_we             = 1'b1;
              dec.wdata.pressed      = 1'b0;
              dec.wdata.velocity     = item.velocity;
              dec.wdata.channel      = item.channel;
              dec.wdata.future       = item.future;
              dec.wdata.marked       = 1'b0;
              dec.wdata.release_time = 32'd0;
              dec.live_wr            = 1'b1;
              dec.live_val           = 1'b1;
              // re-added as current soon after its release: cancel it
              if (had_mark && age < hold_window_us) begin
                dn           = 1'b1;
                dec.live_val = 1'b0;
              end
            end
          end
        end
        OP_CLEAR: begin
          clr_one  = 1'b1;
          clr_mark = item.mark;
        end
        OP_PRESS: begin
          if (item.velocity != 7'd0 && is_exp) begin
            if (rd.future == 8'd0) begin
              dec.press_result = RES_EXPECTED;
              dn = 1'b1;
              if (keep_lit) begin
                dec.mem_we        = 1'b1;
                dec.wdata.pressed = 1'b1;
              end else begin
                dec.live_wr  = 1'b1;
                dec.live_val = 1'b0;
              end
            end else if (count == 9'd0) begin
              dec.press_result     = RES_SKIPPED;
              dec.skipped_distance = rd.future;
              clr_one  = 1'b1;
              clr_mark = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (clr_one) begin
      if (is_prs) begin
        dec.live_wr  = 1'b1;
        dec.live_val = 1'b0;
      end else if (is_exp) begin
        if (rd.future == 8'd0) begin
          dn           = 1'b1;
          dec.live_wr  = 1'b1;
          dec.live_val = 1'b0;
        end else if (clr_mark) begin
          dec.mem_we             = 1'b1;
          dec.wdata.marked       = 1'b1;
          dec.wdata.release_time = item.now_us;
        end
      end
    end
    // saturating count: rise first, then fall
    c_up          = (up && count != COUNT_MAX) ? count + 9'd1 : count;
    dec.count_nxt = (dn && c_up != 9'd0) ? c_up - 9'd1 : c_up;
  end

endmodule

`default_nettype wire
